// ----- rtl/rcpg_pkg.sv -----
// shared types and constants of the rectangle color pattern generator
`default_nettype none
package rcpg_pkg;

  localparam int unsigned CoordWidthDef = 11;
  localparam int unsigned OutCoordW     = 11;
  localparam int unsigned CfgAddrW      = 3;
  localparam int unsigned CfgDataW      = 32;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_RECT_COUNT    = 3'd0,
    CFG_RECT_WIDTH    = 3'd1,
    CFG_RECT_HEIGHT   = 3'd2,
    CFG_FIRST_COLOR   = 3'd3,
    CFG_COLOR_STEP    = 3'd4,
    CFG_INDEXED_MODE  = 3'd5,
    CFG_CHANNEL_SIZES = 3'd6,
    CFG_CHANNEL_POS   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  rect_count;
    logic [10:0] rect_width;
    logic [10:0] rect_height;
    logic [31:0] first_color;
    logic [7:0]  color_step;
    logic        indexed_mode;
    logic [11:0] channel_sizes;
    logic [14:0] channel_positions;
  } cfg_t;

  typedef struct packed {
    logic [7:0]           row;
    logic [7:0]           col;
    logic [OutCoordW-1:0] x;
    logic [OutCoordW-1:0] y;
    logic                 last;
  } pixel_t;

  typedef struct packed {
    logic s2_load;
    logic out_load;
  } pipe_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/rcpg_scan.sv -----
// raster scan counters and the captured pixel word
`default_nettype none
module rcpg_scan #(
  parameter int unsigned COORD_WIDTH = rcpg_pkg::CoordWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic            restart_i,
  input  wire rcpg_pkg::cfg_t  cfg_i,
  output rcpg_pkg::pixel_t     pixel_o
);

  logic [COORD_WIDTH-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [7:0]             grid_col_q, grid_col_d, grid_row_q, grid_row_d;
  logic [10:0]            inner_x_q, inner_x_d, inner_y_q, inner_y_d;
  rcpg_pkg::pixel_t       pixel_q;

  logic [COORD_WIDTH-1:0] px, py;
  logic [7:0]             col, row, n;
  logic [10:0]            ix, iy, w, h;
  logic                   end_x, end_row, end_y, end_col;

  always_comb begin
    n  = (cfg_i.rect_count  == '0) ? 8'd1  : cfg_i.rect_count;
    w  = (cfg_i.rect_width  == '0) ? 11'd1 : cfg_i.rect_width;
    h  = (cfg_i.rect_height == '0) ? 11'd1 : cfg_i.rect_height;
    px  = restart_i ? '0 : pos_x_q;
    py  = restart_i ? '0 : pos_y_q;
    col = restart_i ? '0 : grid_col_q;
    row = restart_i ? '0 : grid_row_q;
    ix  = restart_i ? '0 : inner_x_q;
    iy  = restart_i ? '0 : inner_y_q;

    end_x   = ix >= (w - 11'd1);
    end_row = end_x && (col >= (n - 8'd1));
    end_y   = iy >= (h - 11'd1);
    end_col = end_y && (row >= (n - 8'd1));

    pos_x_d    = px;
    pos_y_d    = py;
    grid_col_d = col;
    grid_row_d = row;
    inner_x_d  = ix;
    inner_y_d  = iy;
    if (!end_x) begin
      inner_x_d = ix + 11'd1;
      pos_x_d   = px + COORD_WIDTH'(1);
    end else if (!end_row) begin
      inner_x_d  = '0;
      grid_col_d = col + 8'd1;
      pos_x_d    = px + COORD_WIDTH'(1);
    end else begin
      inner_x_d  = '0;
      grid_col_d = '0;
      pos_x_d    = '0;
      if (!end_y) begin
        inner_y_d = iy + 11'd1;
        pos_y_d   = py + COORD_WIDTH'(1);
      end else if (!end_col) begin
        inner_y_d  = '0;
        grid_row_d = row + 8'd1;
        pos_y_d    = py + COORD_WIDTH'(1);
      end else begin
        inner_y_d  = '0;
        grid_row_d = '0;
        pos_y_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      grid_col_q <= '0;
      grid_row_q <= '0;
      inner_x_q  <= '0;
      inner_y_q  <= '0;
    end else if (accept_i) begin
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      grid_col_q <= grid_col_d;
      grid_row_q <= grid_row_d;
      inner_x_q  <= inner_x_d;
      inner_y_q  <= inner_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pixel_q.row  <= row;
      pixel_q.col  <= col;
      pixel_q.x    <= rcpg_pkg::OutCoordW'(px);
      pixel_q.y    <= rcpg_pkg::OutCoordW'(py);
      pixel_q.last <= end_row && end_col;
    end
  end

  assign pixel_o = pixel_q;

endmodule
`default_nettype wire

// ----- rtl/rcpg_color.sv -----
// color path: product stage, then channel arithmetic into the result register
`default_nettype none
module rcpg_color (
  input  wire logic                 clk_i,
  input  wire rcpg_pkg::cfg_t       cfg_i,
  input  wire rcpg_pkg::pipe_ctrl_t ctrl_i,
  input  wire rcpg_pkg::pixel_t     pixel_i,
  output logic [rcpg_pkg::OutCoordW-1:0] pixel_x_o,
  output logic [rcpg_pkg::OutCoordW-1:0] pixel_y_o,
  output logic [31:0]                    pixel_color_o,
  output logic                           frame_end_o
);

  function automatic logic [31:0] chan(logic [31:0] first, logic [3:0] size,
                                       logic [4:0] pos, logic [15:0] add);
    logic [15:0] mask;
    logic [15:0] field;
    logic [15:0] v;
    mask  = 16'((17'd1 << size) - 17'd1);
    field = 16'(first >> pos) & mask;
    v     = (field + add) & mask;
    return {16'b0, v} << pos;
  endfunction

  logic [15:0]      p_col_q, p_row_q;
  logic [7:0]       p_nstep_q;
  rcpg_pkg::pixel_t pix2_q;

  logic [7:0]  n;
  logic [15:0] p_col_d, p_row_d, nstep_full, row_nstep;
  logic [7:0]  idx;
  logic [15:0] p_diag;
  logic [31:0] color_d;

  always_comb begin
    n          = (cfg_i.rect_count == '0) ? 8'd1 : cfg_i.rect_count;
    p_col_d    = pixel_i.col * cfg_i.color_step;
    p_row_d    = pixel_i.row * cfg_i.color_step;
    nstep_full = n * cfg_i.color_step;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_load) begin
      p_col_q   <= p_col_d;
      p_row_q   <= p_row_d;
      p_nstep_q <= nstep_full[7:0];
      pix2_q    <= pixel_i;
    end
  end

  always_comb begin
    row_nstep = pix2_q.row * p_nstep_q;
    idx       = cfg_i.first_color[7:0] + row_nstep[7:0] + p_col_q[7:0];
    p_diag    = p_row_q + p_col_q;
    if (cfg_i.indexed_mode) begin
      color_d = {24'b0, idx};
    end else begin
      color_d = chan(cfg_i.first_color, cfg_i.channel_sizes[3:0],
                     cfg_i.channel_positions[4:0], p_col_q)
              | chan(cfg_i.first_color, cfg_i.channel_sizes[7:4],
                     cfg_i.channel_positions[9:5], p_row_q)
              | chan(cfg_i.first_color, cfg_i.channel_sizes[11:8],
                     cfg_i.channel_positions[14:10], p_diag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      pixel_x_o     <= pix2_q.x;
      pixel_y_o     <= pix2_q.y;
      pixel_color_o <= color_d;
      frame_end_o   <= pix2_q.last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rectangle_color_pattern_generator.sv -----
// top level: configuration registers, pipeline control, scan and color path
// Rectangle color test-pattern generator. Every accepted input word yields one
// output word carrying the next pixel of the rectangle grid in raster order,
// its coordinates, its color and an end-of-frame flag; restart_i set in the
// word emits pixel zero of a new frame. The block accepts one word per clock
// cycle in steady state while the output is not stalled. The accepting edge
// loads the scan counters and the pixel word, then the multiplier stage is
// loaded, and then the output register through the channel add and shift.
// A stalled output only stops the input once all three stages hold a word.
// Configuration is to be written through cfg_we_i / cfg_addr_i / cfg_wdata_i
// only while no word is in flight; the user is bound, the block does not enforce it.
`default_nettype none
module rectangle_color_pattern_generator #(
  parameter int unsigned COORD_WIDTH = rcpg_pkg::CoordWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rcpg_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [rcpg_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          restart_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [rcpg_pkg::OutCoordW-1:0]     pixel_x_o,
  output logic [rcpg_pkg::OutCoordW-1:0]     pixel_y_o,
  output logic [31:0]                        pixel_color_o,
  output logic                               frame_end_o
);

  rcpg_pkg::cfg_t       cfg_q;
  rcpg_pkg::pipe_ctrl_t ctrl;
  rcpg_pkg::pixel_t     pixel;

  logic v1_q, v2_q, ov_q;
  logic out_rdy, s2_rdy, s1_rdy, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rect_count        <= 8'd1;
      cfg_q.rect_width        <= 11'd1;
      cfg_q.rect_height       <= 11'd1;
      cfg_q.first_color       <= '0;
      cfg_q.color_step        <= '0;
      cfg_q.indexed_mode      <= 1'b0;
      cfg_q.channel_sizes     <= '0;
      cfg_q.channel_positions <= '0;
    end else if (cfg_we_i) begin
      unique case (rcpg_pkg::cfg_idx_e'(cfg_addr_i))
        rcpg_pkg::CFG_RECT_COUNT:    cfg_q.rect_count        <= cfg_wdata_i[7:0];
        rcpg_pkg::CFG_RECT_WIDTH:    cfg_q.rect_width        <= cfg_wdata_i[10:0];
        rcpg_pkg::CFG_RECT_HEIGHT:   cfg_q.rect_height       <= cfg_wdata_i[10:0];
        rcpg_pkg::CFG_FIRST_COLOR:   cfg_q.first_color       <= cfg_wdata_i[31:0];
        rcpg_pkg::CFG_COLOR_STEP:    cfg_q.color_step        <= cfg_wdata_i[7:0];
        rcpg_pkg::CFG_INDEXED_MODE:  cfg_q.indexed_mode      <= cfg_wdata_i[0];
        rcpg_pkg::CFG_CHANNEL_SIZES: cfg_q.channel_sizes     <= cfg_wdata_i[11:0];
        rcpg_pkg::CFG_CHANNEL_POS:   cfg_q.channel_positions <= cfg_wdata_i[14:0];
      endcase
    end
  end

  // three-stage valid chain
  assign out_rdy = !ov_q || !out_stall_i;
  assign s2_rdy  = !v2_q || out_rdy;
  assign s1_rdy  = !v1_q || s2_rdy;
  assign accept  = in_valid_i && s1_rdy;

  assign ctrl.s2_load  = s2_rdy && v1_q;
  assign ctrl.out_load = out_rdy && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        v1_q <= in_valid_i;
      end
      if (s2_rdy) begin
        v2_q <= v1_q;
      end
      if (out_rdy) begin
        ov_q <= v2_q;
      end
    end
  end

  assign in_stall_o  = !s1_rdy;
  assign out_valid_o = ov_q;

  rcpg_scan #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .restart_i(restart_i),
    .cfg_i    (cfg_q),
    .pixel_o  (pixel)
  );

  rcpg_color u_color (
    .clk_i        (clk_i),
    .cfg_i        (cfg_q),
    .ctrl_i       (ctrl),
    .pixel_i      (pixel),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking testbench for the rectangle color pattern generator
module tb_top;
  import rcpg_pkg::*;

  localparam int unsigned CoordW      = CoordWidthDef;
  localparam int unsigned CoordMask   = (1 << CoordW) - 1;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned TxIdlePct [3] = '{19, 47, 0};
  localparam int unsigned RxIdlePct [3] = '{47, 19, 0};

  typedef struct packed {
    logic [OutCoordW-1:0] x;
    logic [OutCoordW-1:0] y;
    logic [31:0]          color;
    logic                 last;
  } pixel_word_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i  = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 restart_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [OutCoordW-1:0] pixel_x_o;
  logic [OutCoordW-1:0] pixel_y_o;
  logic [31:0]          pixel_color_o;
  logic                 frame_end_o;

  cfg_t          shadow_cfg;
  int unsigned   scan_x = 0, scan_y = 0, scan_col = 0, scan_row = 0;
  int unsigned   sub_x = 0, sub_y = 0;
  bit            restart_queue [$];
  pixel_word_t   pixel_queue [$];
  pixel_word_t   seen_word, due_word;
  int unsigned   idle_mode = 0;
  int unsigned   mismatches = 0, words_in = 0, words_out = 0, frames_seen = 0;
  bit            want_hold = 1'b0;
  int unsigned   hold_cnt = 0;
  int unsigned   idle_cycles = 0;

  rectangle_color_pattern_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .frame_end_o   (frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] channel_field(int unsigned size, int unsigned pos,
                                                int unsigned add);
    logic [63:0] mask;
    logic [63:0] field;
    mask  = (64'd1 << size) - 64'd1;
    field = ({32'd0, shadow_cfg.first_color} >> pos) & mask;
    field = (field + 64'(add)) & mask;
    return 32'(field << pos);
  endfunction

  function automatic logic [31:0] rect_color(int unsigned row, int unsigned col);
    int unsigned n;
    int unsigned step;
    n    = (shadow_cfg.rect_count == 0) ? 1 : shadow_cfg.rect_count;
    step = shadow_cfg.color_step;
    if (shadow_cfg.indexed_mode) begin
      return {24'd0, 8'(shadow_cfg.first_color + (row * n + col) * step)};
    end
    return channel_field(shadow_cfg.channel_sizes[3:0], shadow_cfg.channel_positions[4:0],
                         col * step)
         | channel_field(shadow_cfg.channel_sizes[7:4], shadow_cfg.channel_positions[9:5],
                         row * step)
         | channel_field(shadow_cfg.channel_sizes[11:8], shadow_cfg.channel_positions[14:10],
                         (row + col) * step);
  endfunction

  // emits the pixel under the scan position and advances the raster scan
  function automatic pixel_word_t next_pixel(bit restart);
    pixel_word_t px;
    int unsigned n, w, h;
    bit          end_x, end_row, end_y, end_col;
    n = (shadow_cfg.rect_count == 0) ? 1 : shadow_cfg.rect_count;
    w = (shadow_cfg.rect_width == 0) ? 1 : shadow_cfg.rect_width;
    h = (shadow_cfg.rect_height == 0) ? 1 : shadow_cfg.rect_height;
    if (restart) begin
      scan_x = 0; scan_y = 0; scan_col = 0; scan_row = 0; sub_x = 0; sub_y = 0;
    end
    end_x   = (sub_x + 1 >= w);
    end_row = end_x && (scan_col + 1 >= n);
    end_y   = (sub_y + 1 >= h);
    end_col = end_y && (scan_row + 1 >= n);
    px.x     = scan_x[OutCoordW-1:0];
    px.y     = scan_y[OutCoordW-1:0];
    px.color = rect_color(scan_row, scan_col);
    px.last  = end_row && end_col;
    if (!end_x) begin
      sub_x++;
      scan_x = (scan_x + 1) & CoordMask;
    end else if (!end_row) begin
      sub_x    = 0;
      scan_col = (scan_col + 1) & 8'hFF;
      scan_x   = (scan_x + 1) & CoordMask;
    end else begin
      sub_x = 0; scan_col = 0; scan_x = 0;
      if (!end_y) begin
        sub_y++;
        scan_y = (scan_y + 1) & CoordMask;
      end else if (!end_col) begin
        sub_y    = 0;
        scan_row = (scan_row + 1) & 8'hFF;
        scan_y   = (scan_y + 1) & CoordMask;
      end else begin
        sub_y = 0; scan_row = 0; scan_y = 0;
      end
    end
    return px;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
  endtask

  // unused upper bits of each register word carry random noise
  task automatic load_config(cfg_t c);
    write_reg(CFG_RECT_COUNT, {24'($urandom), c.rect_count});
    write_reg(CFG_RECT_WIDTH, {21'($urandom), c.rect_width});
    write_reg(CFG_RECT_HEIGHT, {21'($urandom), c.rect_height});
    write_reg(CFG_FIRST_COLOR, c.first_color);
    write_reg(CFG_COLOR_STEP, {24'($urandom), c.color_step});
    write_reg(CFG_INDEXED_MODE, {31'($urandom), c.indexed_mode});
    write_reg(CFG_CHANNEL_SIZES, {20'($urandom), c.channel_sizes});
    write_reg(CFG_CHANNEL_POS, {17'($urandom), c.channel_positions});
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow_cfg = c;
  endtask

  task automatic wait_idle();
    while (restart_queue.size() != 0 || in_valid_i || pixel_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pixel_queue.push_back(next_pixel(restart_i));
        words_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (restart_queue.size() != 0 && $urandom_range(99) >= TxIdlePct[idle_mode]) begin
          in_valid_i <= 1'b1;
          restart_i  <= restart_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          restart_i  <= 1'($urandom);
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_word = {pixel_x_o, pixel_y_o, pixel_color_o, frame_end_o};
        words_out++;
        if (frame_end_o) frames_seen++;
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d color=%h end=%b", $time,
                   seen_word.x, seen_word.y, seen_word.color, seen_word.last);
          mismatches++;
        end else begin
          due_word = pixel_queue.pop_front();
          if (seen_word !== due_word) begin
            $display("%0t: expected x=%0d y=%0d color=%h end=%b, actual x=%0d y=%0d color=%h end=%b",
                     $time, due_word.x, due_word.y, due_word.color, due_word.last,
                     seen_word.x, seen_word.y, seen_word.color, seen_word.last);
            mismatches++;
          end
        end
      end
      if (want_hold && hold_cnt < HoldCycles) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= hold_cnt + 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < RxIdlePct[idle_mode]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles, %0d words still due", $time, IdleLimit,
               pixel_queue.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t        cfg;
    int unsigned phase;
    int unsigned random_items;
    int unsigned n_items;
    int unsigned k;
    shadow_cfg             = '0;
    shadow_cfg.rect_count  = 8'd1;
    shadow_cfg.rect_width  = 11'd1;
    shadow_cfg.rect_height = 11'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: every pixel is a one-pixel frame
    restart_queue = '{1'b0, 1'b0, 1'b1, 1'b0};
    wait_idle();
    // zero count and sizes behave as one, direct mode with byte channels
    cfg = '{8'd0, 11'd0, 11'd0, 32'h00AB_CDEF, 8'h11, 1'b0, 12'h888, 15'h4100};
    load_config(cfg);
    restart_queue = '{1'b1, 1'b0, 1'b0};
    wait_idle();
    // all fields at their maximum, first word continues the old scan
    cfg = '{8'd255, 11'd2047, 11'd2047, 32'hFFFF_FFFF, 8'hFF, 1'b1, 12'hFFF, 15'h7FFF};
    load_config(cfg);
    restart_queue = '{1'b0, 1'b1, 1'b0, 1'b0};
    wait_idle();
    // 2x2 grid, zero-size red and blue, green spills past bit 31
    cfg = '{8'd2, 11'd1, 11'd1, 32'hDEAD_BEEF, 8'h09, 1'b0, 12'h0F0, 15'h7E9C};
    load_config(cfg);
    restart_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    wait_idle();

    phase        = 0;
    random_items = 0;
    while (random_items < RandomItems) begin
      if (random_items < RandomItems / 3) idle_mode = 0;
      else if (random_items < 2 * RandomItems / 3) idle_mode = 1;
      else idle_mode = 2;
      cfg.rect_count  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      cfg.rect_width  = ($urandom_range(7) == 0) ? 11'($urandom) : 11'($urandom_range(3));
      cfg.rect_height = ($urandom_range(7) == 0) ? 11'($urandom) : 11'($urandom_range(3));
      cfg.first_color       = $urandom;
      cfg.color_step        = 8'($urandom);
      cfg.indexed_mode      = 1'($urandom);
      cfg.channel_sizes     = 12'($urandom);
      cfg.channel_positions = 15'($urandom);
      n_items = $urandom_range(20, 90);
      load_config(cfg);
      if (phase == 2) begin
        want_hold = 1'b1;
        n_items   = 150;
      end
      for (k = 0; k < n_items; k++) begin
        restart_queue.push_back((k == 0) ? 1'($urandom) : ($urandom_range(39) == 0));
      end
      wait_idle();
      random_items += n_items;
      phase++;
    end

    repeat (10) @(posedge clk_i);
    $display("%0d config phases, %0d pixel words sent, %0d received, %0d frame ends seen",
             phase + 4, words_in, words_out, frames_seen);
    $display("covered indexed and direct colors, zero and maximum settings, long output stall");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
